// File: rtl/xml_entity_decoder_assert.svh
// ----------------------------------------------------------------------------
// xml_entity_decoder assertion macros
// Shared property wrappers for the entity decoder, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_DECODER_ASSERT_SVH
`define XML_ENTITY_DECODER_ASSERT_SVH

// same-cycle implication
`define XED_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xml_entity_decoder: same-cycle check failed");

// next-cycle implication
`define XED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xml_entity_decoder: next-cycle check failed");

`endif

// File: rtl/xed_pkg.sv
// ----------------------------------------------------------------------------
// xed_pkg
// Beat types, command format and entity table for the XML entity decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

  localparam int HoldDepth = 5;
  localparam int CandDepth = HoldDepth + 1;
  localparam int EntCount  = 8;
  localparam int QueueDepth = 2;

  localparam logic [7:0] ChrAmp = 8'h26;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       output_end;
  } out_beat_t;

  // one classified input: up to six bytes to emit
  typedef struct packed {
    logic [0:CandDepth-1][7:0] bytes;
    logic [2:0]                cnt;
    logic                      str_end;
  } cmd_t;

  // queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [0:CandDepth-1][7:0] ent_text_t;
  typedef logic [0:1][7:0]           ent_out_t;

  // &amp; &lt; &gt; &quot; &apos; &#xA; &#xD; &#x9;
  localparam ent_text_t EntText [EntCount] = '{
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
    '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
    '{8'h26, 8'h23, 8'h78, 8'h41, 8'h3b, 8'h00},
    '{8'h26, 8'h23, 8'h78, 8'h44, 8'h3b, 8'h00},
    '{8'h26, 8'h23, 8'h78, 8'h39, 8'h3b, 8'h00}
  };

  localparam logic [2:0] EntLen [EntCount] = '{
    3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd5, 3'd5, 3'd5
  };

  localparam logic [1:0] EntNout [EntCount] = '{
    2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1
  };

  // quote entities decode to a backslash and the quote
  localparam ent_out_t EntOut [EntCount] = '{
    '{8'h26, 8'h00},
    '{8'h3c, 8'h00},
    '{8'h3e, 8'h00},
    '{8'h5c, 8'h22},
    '{8'h5c, 8'h27},
    '{8'h0a, 8'h00},
    '{8'h0d, 8'h00},
    '{8'h09, 8'h00}
  };

endpackage

// File: rtl/xed_front.sv
// ----------------------------------------------------------------------------
// xed_front
// Holds pending entity bytes, matches each input beat against the entity
// table and turns it into at most one command of up to six output bytes.
// ----------------------------------------------------------------------------
module xed_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  xed_pkg::in_beat_t beat_i,
  output logic              cmd_valid_o,
  output xed_pkg::cmd_t     cmd_o
);
  import xed_pkg::*;

  logic [7:0] held_q [HoldDepth];
  logic [7:0] held_d [HoldDepth];
  logic [2:0] count_q, count_d;

  logic [0:CandDepth-1][7:0] cand;
  logic [2:0] cand_n;
  logic       active, is_amp, complete, prefix, ok;
  logic [2:0] hit;
  cmd_t       cmd;

  // candidate sequence and table match
  always_comb begin
    active = (count_q != 3'd0) && (count_q <= 3'(HoldDepth));
    cand_n = count_q + 3'd1;
    for (int i = 0; i < CandDepth; i++) begin
      if (i < HoldDepth && 3'(i) < count_q) begin
        cand[i] = held_q[(i < HoldDepth) ? i : 0];
      end else begin
        cand[i] = beat_i.in_byte;
      end
    end
    complete = 1'b0;
    prefix   = 1'b0;
    hit      = '0;
    for (int e = 0; e < EntCount; e++) begin
      ok = (EntLen[e] >= cand_n);
      for (int i = 0; i < CandDepth; i++) begin
        if (3'(i) < cand_n && cand[i] != EntText[e][i]) begin
          ok = 1'b0;
        end
      end
      if (ok && EntLen[e] == cand_n && !complete) begin
        complete = 1'b1;
        hit      = 3'(e);
      end else if (ok && EntLen[e] > cand_n) begin
        prefix = 1'b1;
      end
    end
  end

  // command build and hold update
  always_comb begin
    is_amp      = (beat_i.in_byte == ChrAmp);
    held_d      = held_q;
    count_d     = count_q;
    cmd.bytes   = cand;
    cmd.cnt     = 3'd0;
    cmd.str_end = beat_i.string_end;
    if (!active) begin
      if (is_amp) begin
        held_d[0] = beat_i.in_byte;
        count_d   = 3'd1;
        cmd.cnt   = beat_i.string_end ? 3'd1 : 3'd0;
      end else begin
        count_d = 3'd0;
        cmd.cnt = 3'd1;
      end
    end else if (complete) begin
      cmd.bytes[0] = EntOut[hit][0];
      cmd.bytes[1] = EntOut[hit][1];
      cmd.cnt      = {1'b0, EntNout[hit]};
      count_d      = 3'd0;
    end else if (prefix) begin
      held_d[count_q] = beat_i.in_byte;
      count_d         = cand_n;
      cmd.cnt         = beat_i.string_end ? cand_n : 3'd0;
    end else if (is_amp) begin
      // mismatch on '&': flush held bytes, the '&' opens a new entity
      held_d[0] = beat_i.in_byte;
      count_d   = 3'd1;
      cmd.cnt   = beat_i.string_end ? cand_n : count_q;
    end else begin
      count_d = 3'd0;
      cmd.cnt = cand_n;
    end
    if (beat_i.string_end) begin
      count_d = 3'd0;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = take_i && (cmd.cnt != 3'd0);

  // pending count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else if (take_i) begin
      count_q <= count_d;
    end
  end

  // pending bytes
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      held_q <= held_d;
    end
  end

endmodule

// File: rtl/xed_cmd_fifo.sv
// ----------------------------------------------------------------------------
// xed_cmd_fifo
// Short command queue between the classifier and the output serializer.
// ----------------------------------------------------------------------------
module xed_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  xed_pkg::cmd_t    wr_data_i,
  input  logic             rd_i,
  output xed_pkg::cmd_t    rd_data_o,
  output xed_pkg::q_stat_t stat_o
);
  import xed_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;
  logic            do_wr, do_rd;

  assign stat_o.full  = (fill_q == (PtrW+1)'(QueueDepth));
  assign stat_o.empty = (fill_q == '0);
  assign do_wr = wr_i && !stat_o.full;
  assign do_rd = rd_i && !stat_o.empty;
  assign rd_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/xed_back.sv
// ----------------------------------------------------------------------------
// xed_back
// Serializes the head command into output beats, one byte per cycle while
// pop_i is high and a command waits; retires it after its last byte is taken.
// ----------------------------------------------------------------------------
module xed_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xed_pkg::cmd_t      cmd_i,
  input  xed_pkg::q_stat_t   stat_i,
  input  logic               pop_i,
  output logic               cmd_done_o,
  output xed_pkg::out_beat_t beat_o
);
  import xed_pkg::*;

  logic [2:0] idx_q;
  logic       last, take;

  assign last = (idx_q == cmd_i.cnt - 3'd1);
  assign take = pop_i && !stat_i.empty;

  assign beat_o.out_byte   = cmd_i.bytes[idx_q];
  assign beat_o.run_last   = last;
  assign beat_o.output_end = last && cmd_i.str_end;
  assign cmd_done_o        = take && last;

  // byte index within the head command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (take) begin
      idx_q <= last ? 3'd0 : idx_q + 3'd1;
    end
  end

endmodule

// File: rtl/xml_entity_decoder.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Streaming XML entity decoder with queue-style input and output ports.
// ----------------------------------------------------------------------------
// One encoded byte is accepted per cycle while full is low; the classifier
// decides in that cycle what the byte produces and stores it as one command in
// a two-entry queue. The output side delivers one decoded byte per cycle
// while pop is high and empty is low, so a command of several bytes (up to six
// when a pending entity breaks) holds its queue entry until its last byte is
// popped, and the input stalls only once both queue entries are taken. Inputs
// that produce nothing (bytes held as a possible entity) never occupy the
// queue. First output is visible the cycle after the input beat is accepted.
`include "xml_entity_decoder_assert.svh"

module xml_entity_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  xed_pkg::in_beat_t  in_beat_i,
  output logic               empty,
  input  logic               pop,
  output xed_pkg::out_beat_t out_beat_o
);
  import xed_pkg::*;

  logic    take, cmd_valid, cmd_done;
  cmd_t    cmd_in, cmd_head;
  q_stat_t q_stat;

  assign take  = push && !full;
  assign full  = q_stat.full;
  assign empty = q_stat.empty;

  // classifier
  xed_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .beat_i      (in_beat_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in)
  );

  // command queue
  xed_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd_in),
    .rd_i      (cmd_done),
    .rd_data_o (cmd_head),
    .stat_o    (q_stat)
  );

  // output serializer
  xed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_head),
    .stat_i     (q_stat),
    .pop_i      (pop),
    .cmd_done_o (cmd_done),
    .beat_o     (out_beat_o)
  );

  // end of string always yields output
  `XED_ASSERT_NEXT(a_end_gives_output, take && in_beat_i.string_end, !empty)
  // string end only on the final byte of a run
  `XED_ASSERT_NOW(a_end_is_last, !empty && out_beat_o.output_end, out_beat_o.run_last)
  // a full queue always has a result waiting
  `XED_ASSERT_NOW(a_full_not_empty, full, !empty)
  // queued commands carry between one and six bytes
  `XED_ASSERT_NOW(a_head_nonzero, !empty, cmd_head.cnt != 3'd0 && cmd_head.cnt <= 3'd6)

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder testbench
// Streams encoded strings into the decoder with random gaps on both sides and
// checks every decoded beat against a byte-level predictor of the unescaper.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_DEPTH  = 5;
  localparam int ITEM_TARGET = 460;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;

  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef enum int {
    ENT_AMP, ENT_LT, ENT_GT, ENT_QUOT, ENT_APOS, ENT_LF, ENT_CR, ENT_TAB, ENT_NUM
  } entity_e;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  xed_pkg::in_beat_t  in_beat_i;
  logic               empty;
  logic               pop;
  xed_pkg::out_beat_t out_beat_o;

  // predictor state and expected decoded beats
  logic [7:0]         held_bytes [HOLD_DEPTH];
  int                 held_cnt = 0;
  xed_pkg::out_beat_t decoded_q [$];
  logic [7:0]         text_q [$];

  int err_cnt     = 0;
  int beats_sent  = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;
  int pop_wait    = 0;

  xml_entity_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat_i),
    .empty      (empty),
    .pop        (pop),
    .out_beat_o (out_beat_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // encoded form of each entity
  function automatic string ent_text(entity_e e);
    case (e)
      ENT_AMP:  return "&amp;";
      ENT_LT:   return "&lt;";
      ENT_GT:   return "&gt;";
      ENT_QUOT: return "&quot;";
      ENT_APOS: return "&apos;";
      ENT_LF:   return "&#xA;";
      ENT_CR:   return "&#xD;";
      default:  return "&#x9;";
    endcase
  endfunction

  // decoded bytes of each entity, quote entities give two
  function automatic int ent_decoded(entity_e e, output logic [7:0] d0,
                                     output logic [7:0] d1);
    d1 = CH_BSLASH;
    case (e)
      ENT_AMP:  d0 = CH_AMP;
      ENT_LT:   d0 = CH_LT;
      ENT_GT:   d0 = CH_GT;
      ENT_QUOT: begin
        d0 = CH_BSLASH;
        d1 = CH_DQUOTE;
        return 2;
      end
      ENT_APOS: begin
        d0 = CH_BSLASH;
        d1 = CH_SQUOTE;
        return 2;
      end
      ENT_LF:   d0 = CH_LF;
      ENT_CR:   d0 = CH_CR;
      default:  d0 = CH_TAB;
    endcase
    return 1;
  endfunction

  function automatic int draw_gap();
    if (steady) return 0;
    return $urandom_range(0, 8);
  endfunction

  // byte-level unescaper: updates held state, queues the decoded beats
  function automatic void decode_byte(xed_pkg::in_beat_t b);
    logic [7:0]         outs [$];
    logic [7:0]         cand [HOLD_DEPTH+1];
    logic [7:0]         d0;
    logic [7:0]         d1;
    xed_pkg::out_beat_t r;
    string              t;
    int                 n;
    int                 nd;
    bit                 prefix;
    bit                 done;
    bit                 match;
    prefix = 1'b0;
    done   = 1'b0;
    if (held_cnt != 0) begin
      for (int i = 0; i < held_cnt; i++) cand[i] = held_bytes[i];
      cand[held_cnt] = b.in_byte;
      n = held_cnt + 1;
      for (int e = 0; e < ENT_NUM && !done; e++) begin
        t = ent_text(entity_e'(e));
        if (t.len() >= n) begin
          match = 1'b1;
          for (int i = 0; i < n; i++) if (cand[i] != t[i]) match = 1'b0;
          if (match && t.len() == n) begin
            nd = ent_decoded(entity_e'(e), d0, d1);
            outs = {outs, d0};
            if (nd == 2) outs = {outs, d1};
            held_cnt = 0;
            done = 1'b1;
          end else if (match) begin
            prefix = 1'b1;
          end
        end
      end
      if (!done && prefix && n <= HOLD_DEPTH) begin
        held_bytes[n-1] = b.in_byte;
        held_cnt = n;
        done = 1'b1;
      end else if (!done) begin
        // broken entity: held bytes go out literally
        for (int i = 0; i < held_cnt; i++) outs = {outs, held_bytes[i]};
        held_cnt = 0;
      end
    end
    // byte handled with nothing pending
    if (!done) begin
      if (b.in_byte == CH_AMP) begin
        held_bytes[0] = b.in_byte;
        held_cnt = 1;
      end else begin
        outs = {outs, b.in_byte};
      end
    end
    // end of string flushes whatever is still held
    if (b.string_end) begin
      for (int i = 0; i < held_cnt; i++) outs = {outs, held_bytes[i]};
      held_cnt = 0;
    end
    foreach (outs[k]) begin
      r.out_byte   = outs[k];
      r.run_last   = (k == outs.size() - 1);
      r.output_end = (k == outs.size() - 1) && b.string_end;
      decoded_q = {decoded_q, r};
    end
  endfunction

  // one input beat, called and returning at a falling edge
  task automatic send_beat(input logic [7:0] data, input logic last);
    xed_pkg::in_beat_t b;
    int gap;
    gap = draw_gap();
    b.in_byte    = data;
    b.string_end = last;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_byte(b);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic ends);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], ends && (i == s.len() - 1));
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic void check_field(string name, int unsigned expv,
                                      int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
      err_cnt++;
    end
  endfunction

  // output side: random pop stalls, compare each accepted beat
  initial begin : drain_proc
    xed_pkg::out_beat_t exp_beat;
    pop = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %0h", $time, out_beat_o);
          err_cnt++;
        end else begin
          exp_beat = decoded_q.pop_front();
          check_field("out_byte", exp_beat.out_byte, out_beat_o.out_byte);
          check_field("run_last", exp_beat.run_last, out_beat_o.run_last);
          check_field("output_end", exp_beat.output_end, out_beat_o.output_end);
        end
        pop_wait = draw_gap();
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("xml_entity_decoder test failed");
        $finish;
      end
    end
  end

  // complete entities, including one closing the string
  task automatic test_entity_decode();
    steady = 1'b1;
    send_text("&quot;", 1'b1);
    steady = 1'b0;
    send_text("&lt;", 1'b1);
  endtask

  // broken entities, longest hold broken, new entity started by the breaker
  task automatic test_broken_entity();
    send_text("&#x9&", 1'b1);
    send_text("&apos", 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  // byte 0xff and a lone ampersand at end of string
  task automatic test_byte_extremes();
    send_beat(8'hff, 1'b1);
    send_beat(CH_AMP, 1'b1);
  endtask

  // append one random token of encoded text
  task automatic add_token();
    string t;
    int    sel;
    int    cut;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    t = ent_text(entity_e'($urandom_range(0, ENT_NUM - 1)));
    if (sel < 45) begin
      for (int i = 0; i < t.len(); i++) text_q = {text_q, t[i]};
    end else if (sel < 60) begin
      // truncated entity
      cut = $urandom_range(1, t.len() - 1);
      for (int i = 0; i < cut; i++) text_q = {text_q, t[i]};
    end else if (sel < 72) begin
      // near miss: one byte flipped in case or replaced
      cut = $urandom_range(1, t.len() - 1);
      for (int i = 0; i < t.len(); i++) begin
        c = t[i];
        if (i == cut) c = $urandom_range(0, 1) ? (c ^ CASE_BIT) : 8'($urandom_range(0, 255));
        text_q = {text_q, c};
      end
    end else if (sel < 80) begin
      text_q = {text_q, CH_AMP};
    end else begin
      text_q = {text_q, 8'($urandom_range(0, 255))};
    end
  endtask

  // random strings, well-formed entities mixed with noise
  task automatic test_random_text();
    bit paused;
    paused = 1'b0;
    while (beats_sent < ITEM_TARGET) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) add_token();
      steady = ($urandom_range(0, 3) == 0);
      foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
      if (!paused && beats_sent > ITEM_TARGET / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    steady = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_ni    = 1'b0;
    push      = 1'b0;
    in_beat_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_entity_decode();
    test_broken_entity();
    test_byte_extremes();
    hold_until_drained();
    test_random_text();

    // wait for the last beats, then a quiet tail for stray output
    hold_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("xml_entity_decoder test passed");
    end else begin
      $display("xml_entity_decoder test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/xed_pkg.sv
rtl/xed_front.sv
rtl/xed_cmd_fifo.sv
rtl/xed_back.sv
rtl/xml_entity_decoder.sv
test/testbench.sv
